### hdl/fca_pkg.sv
`timescale 1ns / 1ps

package fca_pkg;

  // Table geometry
  localparam int unsigned MAX_BLOCKS = 4096;
  localparam int unsigned BLK_W      = 12;   // block number width
  localparam int unsigned CNT_W      = 13;   // holds 0 .. MAX_BLOCKS
  localparam int unsigned LINK_W     = 16;   // width of one table entry

  localparam logic [LINK_W-1:0] END_MARK   = 16'hFFFF;
  localparam logic [LINK_W-1:0] ENTRY_FREE = 16'h0000;

  // Operation codes
  localparam logic [2:0] OP_FORMAT   = 3'd0;
  localparam logic [2:0] OP_CREATE   = 3'd1;
  localparam logic [2:0] OP_EXTEND   = 3'd2;
  localparam logic [2:0] OP_TRUNCATE = 3'd3;
  localparam logic [2:0] OP_FREE     = 3'd4;
  localparam logic [2:0] OP_NEXT     = 3'd5;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_FAULT = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // Configuration register indexes
  localparam logic CFG_FIRST_DATA  = 1'b0;
  localparam logic CFG_BLOCK_COUNT = 1'b1;

  // One table access request: a read and a write port
  typedef struct packed {
    logic              re;
    logic [BLK_W-1:0]  raddr;
    logic              we;
    logic [BLK_W-1:0]  waddr;
    logic [LINK_W-1:0] wdata;
  } tbl_req_t;

endpackage

### hdl/fca_table.sv
`timescale 1ns / 1ps

// Allocation table: one write and one registered read per cycle.
module fca_table
  import fca_pkg::*;
(
  input  logic              clk_i,
  input  tbl_req_t          req_i,
  output logic [LINK_W-1:0] rdata_o
);

  logic [LINK_W-1:0] mem [MAX_BLOCKS];
  logic [LINK_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/fat_chain_allocator_core.sv
`timescale 1ns / 1ps

// Block allocation table keeper. The table (4096 x 16 bit) sits in one
// single-port-read, single-port-write RAM and every operation runs as a short
// sequence of reads and writes on it, one operation at a time. After reset the
// block runs a clearing pass that frees every entry and takes no word until it
// ends; format runs the same sweep but marks the reserved entries as chain ends.
// Create and extend scan for the first free entry one read per cycle; free and
// truncate walk the chain, reading then freeing each block; next reads one entry.
// Out-of-range blocks and unused codes go straight to the answer. A result sits
// in an output register, so a new word is taken while the previous result waits.
// Configuration must be written only while idle; the block does not enforce it.
module fat_chain_allocator_core
  import fca_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [12:0] cfg_wdata_i,
  // input words
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // operation[2:0], block[14:3], zero pad
  // result words
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // status[1:0], result_block[13:2], is_end[14], pad
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SWEEP   = 4'd1;
  localparam logic [3:0] S_SCAN    = 4'd2;
  localparam logic [3:0] S_LINK    = 4'd3;
  localparam logic [3:0] S_HEAD    = 4'd4;
  localparam logic [3:0] S_WALK    = 4'd5;
  localparam logic [3:0] S_WALK_RD = 4'd6;
  localparam logic [3:0] S_TAIL    = 4'd7;
  localparam logic [3:0] S_NEXT    = 4'd8;
  localparam logic [3:0] S_FIN     = 4'd9;

  logic [3:0]        state_q, state_d;
  logic [BLK_W-1:0]  first_data_q;
  logic [CNT_W-1:0]  block_count_q;
  logic [2:0]        op_q, op_d;
  logic [BLK_W-1:0]  blk_q, blk_d;
  logic [CNT_W-1:0]  scan_q, scan_d;
  logic              pend_q, pend_d;
  logic [BLK_W-1:0]  pend_addr_q, pend_addr_d;
  logic [BLK_W-1:0]  found_q, found_d;
  logic [LINK_W-1:0] cur_q, cur_d;
  logic [CNT_W-1:0]  steps_q, steps_d;
  logic [BLK_W-1:0]  sweep_q, sweep_d;
  logic              fmt_q, fmt_d;
  logic [1:0]        status_q, status_d;
  logic [BLK_W-1:0]  res_blk_q, res_blk_d;
  logic              res_end_q, res_end_d;
  logic              m_valid_q, m_valid_d;
  logic [15:0]       m_data_q, m_data_d;

  tbl_req_t          tbl_req;
  logic [LINK_W-1:0] tbl_rdata;

  logic [CNT_W-1:0]  n_blocks;
  logic              in_acc;
  logic [2:0]        in_op;
  logic [BLK_W-1:0]  in_blk;
  logic              in_range;
  logic              out_free;
  logic              cur_end;
  logic              cur_bad;
  logic              sweep_rsvd;

  fca_table u_table (
    .clk_i   (clk_i),
    .req_i   (tbl_req),
    .rdata_o (tbl_rdata)
  );

  // Active size: block count saturated to the table depth
  assign n_blocks = (block_count_q > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : block_count_q;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign in_op    = s_axis_tdata_i[2:0];
  assign in_blk   = s_axis_tdata_i[14:3];
  assign in_range = ({1'b0, in_blk} < n_blocks);
  assign out_free = !m_valid_q || m_axis_tready_i;

  assign cur_end    = (cur_q == END_MARK) || (cur_q == ENTRY_FREE);
  assign cur_bad    = (cur_q >= LINK_W'(n_blocks)) || (steps_q >= n_blocks);
  assign sweep_rsvd = ({1'b0, sweep_q} < CNT_W'(first_data_q)) &&
                      ({1'b0, sweep_q} < n_blocks);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_data_q  <= BLK_W'(2);
      block_count_q <= CNT_W'(MAX_BLOCKS);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FIRST_DATA:  first_data_q  <= cfg_wdata_i[BLK_W-1:0];
        CFG_BLOCK_COUNT: block_count_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Operation sequencer
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    blk_d       = blk_q;
    scan_d      = scan_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    found_d     = found_q;
    cur_d       = cur_q;
    steps_d     = steps_q;
    sweep_d     = sweep_q;
    fmt_d       = fmt_q;
    status_d    = status_q;
    res_blk_d   = res_blk_q;
    res_end_d   = res_end_q;
    m_valid_d   = m_valid_q && !m_axis_tready_i;
    m_data_d    = m_data_q;
    tbl_req     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d      = in_op;
          blk_d     = in_blk;
          status_d  = ST_OK;
          res_blk_d = '0;
          res_end_d = 1'b0;
          unique case (in_op)
            OP_FORMAT: begin
              sweep_d = '0;
              fmt_d   = 1'b1;
              state_d = S_SWEEP;
            end
            OP_CREATE: begin
              scan_d  = CNT_W'(first_data_q);
              state_d = S_SCAN;
            end
            OP_EXTEND: begin
              scan_d  = CNT_W'(first_data_q);
              state_d = in_range ? S_SCAN : S_FIN;
            end
            OP_TRUNCATE: begin
              tbl_req.re    = in_range;
              tbl_req.raddr = in_blk;
              state_d       = in_range ? S_HEAD : S_FIN;
            end
            OP_FREE: begin
              cur_d   = LINK_W'(in_blk);
              steps_d = '0;
              state_d = in_range ? S_WALK : S_FIN;
            end
            OP_NEXT: begin
              tbl_req.re    = in_range;
              tbl_req.raddr = in_blk;
              state_d       = in_range ? S_NEXT : S_FIN;
            end
            default: state_d = S_FIN;
          endcase
          if (!in_range && (in_op == OP_EXTEND || in_op == OP_TRUNCATE ||
                            in_op == OP_FREE || in_op == OP_NEXT)) begin
            status_d = ST_RANGE;
          end
        end
      end

      // Clear after reset, or format: reserved entries end, the rest free
      S_SWEEP: begin
        tbl_req.we    = 1'b1;
        tbl_req.waddr = sweep_q;
        tbl_req.wdata = (fmt_q && sweep_rsvd) ? END_MARK : ENTRY_FREE;
        sweep_d       = sweep_q + BLK_W'(1);
        if (sweep_q == {BLK_W{1'b1}}) begin
          state_d = fmt_q ? S_FIN : S_IDLE;
        end
      end

      // Pipelined search for the first free entry
      S_SCAN: begin
        if (pend_q && (tbl_rdata == ENTRY_FREE)) begin
          found_d   = pend_addr_q;
          res_blk_d = pend_addr_q;
          tbl_req.we = 1'b1;
          if (op_q == OP_EXTEND) begin
            tbl_req.waddr = blk_q;
            tbl_req.wdata = LINK_W'(pend_addr_q);
            state_d       = S_LINK;
          end else begin
            tbl_req.waddr = pend_addr_q;
            tbl_req.wdata = END_MARK;
            state_d       = S_FIN;
          end
        end else if (scan_q < n_blocks) begin
          tbl_req.re    = 1'b1;
          tbl_req.raddr = scan_q[BLK_W-1:0];
          pend_d        = 1'b1;
          pend_addr_d   = scan_q[BLK_W-1:0];
          scan_d        = scan_q + CNT_W'(1);
        end else begin
          status_d = ST_FULL;
          state_d  = S_FIN;
        end
      end

      // Extend: new block becomes the tail
      S_LINK: begin
        tbl_req.we    = 1'b1;
        tbl_req.waddr = found_q;
        tbl_req.wdata = END_MARK;
        state_d       = S_FIN;
      end

      // Truncate: link of the head starts the walk
      S_HEAD: begin
        cur_d   = tbl_rdata;
        steps_d = '0;
        state_d = S_WALK;
      end

      // Chain walk: check the current link, read its entry
      S_WALK: begin
        if (cur_end) begin
          state_d = (op_q == OP_TRUNCATE) ? S_TAIL : S_FIN;
        end else if (cur_bad) begin
          status_d = ST_FAULT;
          state_d  = (op_q == OP_TRUNCATE) ? S_TAIL : S_FIN;
        end else begin
          tbl_req.re    = 1'b1;
          tbl_req.raddr = cur_q[BLK_W-1:0];
          state_d       = S_WALK_RD;
        end
      end

      // Free the visited entry and follow its link
      S_WALK_RD: begin
        tbl_req.we    = 1'b1;
        tbl_req.waddr = cur_q[BLK_W-1:0];
        tbl_req.wdata = ENTRY_FREE;
        cur_d         = tbl_rdata;
        steps_d       = steps_q + CNT_W'(1);
        state_d       = S_WALK;
      end

      // Truncate: head keeps its place as chain end
      S_TAIL: begin
        tbl_req.we    = 1'b1;
        tbl_req.waddr = blk_q;
        tbl_req.wdata = END_MARK;
        state_d       = S_FIN;
      end

      // Next: classify the link
      S_NEXT: begin
        if (tbl_rdata == END_MARK || tbl_rdata == ENTRY_FREE) begin
          res_end_d = 1'b1;
        end else if (tbl_rdata >= LINK_W'(n_blocks)) begin
          status_d = ST_FAULT;
        end else begin
          res_blk_d = tbl_rdata[BLK_W-1:0];
        end
        state_d = S_FIN;
      end

      // Hand the result to the output register
      S_FIN: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {1'b0, res_end_q, res_blk_q, status_q};
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_SWEEP;
      sweep_q   <= '0;
      fmt_q     <= 1'b0;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      sweep_q   <= sweep_d;
      fmt_q     <= fmt_d;
      pend_q    <= pend_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    blk_q       <= blk_d;
    scan_q      <= scan_d;
    pend_addr_q <= pend_addr_d;
    found_q     <= found_d;
    cur_q       <= cur_d;
    steps_q     <= steps_d;
    status_q    <= status_d;
    res_blk_q   <= res_blk_d;
    res_end_q   <= res_end_d;
    m_data_q    <= m_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule
